// ----- rtl/rmth_pkg.sv -----
// Package: running-median widths, heap depth, heap request/response types.
package rmth_pkg;
  localparam int HEAP_DEPTH = 512;
  localparam int VALUE_WIDTH = 32;
  localparam int AW = $clog2(HEAP_DEPTH + 1);   // 1-based heap index
  localparam int CW = $clog2(HEAP_DEPTH + 1);   // count 0..HEAP_DEPTH

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] count_t;

  // heap operation request/response between sequencer and heap
  typedef struct packed {
    logic   push;
    logic   pop;
    value_t key;
  } heap_req_t;

  typedef struct packed {
    logic   done;
    value_t popped;
    value_t top;
  } heap_rsp_t;
endpackage

// ----- rtl/rmth_if.sv -----
// Valid/ready channel interface carrying a generic payload.
interface rmth_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rmth_heap.sv -----
// One binary heap in a memory, with iterative push and pop sift sequencer.
module rmth_heap import rmth_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      is_min,
  input  logic      clear,
  input  heap_req_t req,
  output heap_rsp_t rsp,
  output count_t    count
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;  // push: read parent, or write root
  localparam logic [2:0] S_UPCK = 3'd2;  // push: compare with parent
  localparam logic [2:0] S_LAST = 3'd3;  // pop: latch last entry
  localparam logic [2:0] S_DNRA = 3'd4;  // pop: read left child
  localparam logic [2:0] S_DNRB = 3'd5;  // pop: read right child
  localparam logic [2:0] S_DNCK = 3'd6;  // pop: pick child, compare

  value_t mem [1:HEAP_DEPTH];
  logic [2:0] state;
  addr_t idx;
  addr_t raddr;
  value_t rdata;
  logic we;
  addr_t waddr;
  value_t wdata;
  value_t key;
  value_t top;
  value_t popped;
  value_t child_a;
  logic done;
  logic [AW:0] c2;
  logic pick_b;
  value_t best;
  addr_t best_i;
  logic sift;

  function automatic logic goes_first(value_t a, value_t b, logic mn);
    goes_first = mn ? (a < b) : (a > b);
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign c2 = {idx, 1'b0};
  // right child only counts when its index lies within the count
  assign pick_b = (c2 < {1'b0, count}) && goes_first(rdata, child_a, is_min);
  assign best = pick_b ? rdata : child_a;
  assign best_i = pick_b ? c2[AW-1:0] + addr_t'(1) : c2[AW-1:0];
  assign sift = goes_first(best, key, is_min);

  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = key;
    raddr = idx;
    case (state)
      S_IDLE: raddr = addr_t'(count);   // last entry, used by a pop
      S_UP: begin
        if (idx == addr_t'(1)) we = 1'b1;
        else raddr = idx >> 1;
      end
      S_UPCK: begin
        we = 1'b1;
        if (goes_first(key, rdata, is_min)) wdata = rdata;
      end
      S_LAST: ;
      S_DNRA: begin
        if (c2 > {1'b0, count}) we = 1'b1;
        else raddr = c2[AW-1:0];
      end
      S_DNRB: raddr = c2[AW-1:0] + addr_t'(1);
      S_DNCK: begin
        we = 1'b1;
        if (sift) wdata = best;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (clear) count <= '0;
          else if (req.push) begin
            count <= count + count_t'(1);
            idx <= addr_t'(count) + addr_t'(1);
            key <= req.key;
            state <= S_UP;
          end else if (req.pop) begin
            popped <= top;
            count <= count - count_t'(1);
            idx <= addr_t'(1);
            state <= S_LAST;
          end
        end
        S_UP: begin
          if (idx == addr_t'(1)) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else state <= S_UPCK;
        end
        S_UPCK: begin
          if (goes_first(key, rdata, is_min)) begin
            idx <= idx >> 1;
            state <= S_UP;
          end else begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_LAST: begin
          key <= rdata;
          if (count == '0) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else state <= S_DNRA;
        end
        S_DNRA: begin
          if (c2 > {1'b0, count}) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else state <= S_DNRB;
        end
        S_DNRB: begin
          child_a <= rdata;
          state <= S_DNCK;
        end
        S_DNCK: begin
          if (sift) begin
            idx <= best_i;
            state <= S_DNRA;
          end else begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // top register mirrors entry 1
  always_ff @(posedge clk) begin
    if (we && waddr == addr_t'(1)) top <= wdata;
  end

  assign rsp = '{done, popped, top};
endmodule

// ----- rtl/running_median_two_heaps_core.sv -----
// Running median top level: two heaps and a per-sample sequencer.
// channel | dir | payload
// in_ch   | in  | sample_value[31:0] signed, start_new
// out_ch  | out | median_value[31:0] signed, held_count[10:0], overflow
// Per sample: decide, push into one heap; if that heap now leads by two, pop its top and
// push it into the other heap; then load the output. A sample for a full heap is dropped.
// in_ch is ready only while idle, so a new sample is taken only after the last is loaded.
// Reset clears both counts; heap memories are not cleared.
// A result waits in the output register; the next one waits for it to drain.
module running_median_two_heaps_core import rmth_pkg::*; (
  input logic clk,
  input logic rst,
  rmth_if.sink   in_ch,
  rmth_if.source out_ch
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_WPUSH = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_WPOP  = 3'd4;
  localparam logic [2:0] S_MOVE  = 3'd5;
  localparam logic [2:0] S_WMOVE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  heap_req_t ureq, lreq;
  heap_rsp_t ursp, lrsp;
  count_t ucnt, lcnt;
  logic clr;
  logic to_upper;
  logic go_up;
  logic full;
  logic ovf;
  value_t key;
  logic ovalid;
  logic [VALUE_WIDTH+CW+1:0] odata;
  value_t sv;
  logic sn;
  value_t med;
  logic [CW:0] held;
  logic out_load;

  rmth_heap u_upper (.clk, .rst, .is_min(1'b1), .clear(clr), .req(ureq),
    .rsp(ursp), .count(ucnt));
  rmth_heap u_lower (.clk, .rst, .is_min(1'b0), .clear(clr), .req(lreq),
    .rsp(lrsp), .count(lcnt));

  assign sv = value_t'(in_ch.data[VALUE_WIDTH:1]);
  assign sn = in_ch.data[0];
  assign in_ch.ready = (state == S_IDLE);
  assign clr = in_ch.valid && in_ch.ready && sn;

  assign go_up = (ucnt == '0) || (key >= ursp.top);
  assign full = go_up ? (ucnt >= count_t'(HEAP_DEPTH))
                      : (lcnt >= count_t'(HEAP_DEPTH));

  always_comb begin
    ureq = '0;
    lreq = '0;
    case (state)
      S_DEC: begin
        if (!full) begin
          if (go_up) begin
            ureq.push = 1'b1;
            ureq.key = key;
          end else begin
            lreq.push = 1'b1;
            lreq.key = key;
          end
        end
      end
      S_POP: begin
        if (to_upper) ureq.pop = 1'b1;
        else lreq.pop = 1'b1;
      end
      S_MOVE: begin
        if (to_upper) begin
          lreq.push = 1'b1;
          lreq.key = ursp.popped;
        end else begin
          ureq.push = 1'b1;
          ureq.key = lrsp.popped;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            key <= sv;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          to_upper <= go_up;
          ovf <= full;
          state <= full ? S_OUT : S_WPUSH;
        end
        S_WPUSH: begin
          if (ursp.done || lrsp.done) begin
            // rebalance when the grown heap leads by two
            if (to_upper ? (ucnt > lcnt + count_t'(1)) : (lcnt > ucnt + count_t'(1)))
              state <= S_POP;
            else state <= S_OUT;
          end
        end
        S_POP: state <= S_WPOP;
        S_WPOP: if (ursp.done || lrsp.done) state <= S_MOVE;
        S_MOVE: state <= S_WMOVE;
        S_WMOVE: if (ursp.done || lrsp.done) state <= S_OUT;
        S_OUT: if (!ovalid || out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (ucnt == lcnt + count_t'(1)) med = ursp.top;
    else if (lcnt != '0) med = lrsp.top;
    else med = '0;
  end

  assign held = {1'b0, ucnt} + {1'b0, lcnt};
  assign out_load = (state == S_OUT) && (!ovalid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (out_load) ovalid <= 1'b1;
    else if (out_ch.ready) ovalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) odata <= {med, held, ovf};
  end

  assign out_ch.valid = ovalid;
  assign out_ch.data = odata;
endmodule

// ----- rtl/rmth_checker.sv -----
// Port-level checker for the running median core, with bind.
module rmth_checker import rmth_pkg::*; (
  input logic clk,
  input logic rst,
  input logic iv, ir, ov, orr,
  input logic [VALUE_WIDTH+CW+1:0] od
);
  a1: assert property (@(posedge clk) disable iff (rst) ov && !orr |=> ov)
    else $error("result dropped");
  a2: assert property (@(posedge clk) disable iff (rst) ov && !orr |=> $stable(od))
    else $error("result changed while waiting");
  a3: assert property (@(posedge clk) disable iff (rst) iv && ir |=> !ir)
    else $error("accepted while busy");
  a4: assert property (@(posedge clk) rst |=> !ov)
    else $error("result valid out of reset");
endmodule

bind running_median_two_heaps_core rmth_checker u_chk (.clk, .rst,
  .iv(in_ch.valid), .ir(in_ch.ready), .ov(out_ch.valid), .orr(out_ch.ready),
  .od(out_ch.data));

// ----- tb/running_median_two_heaps_core_tb.sv -----
// Testbench for the running median core: random and directed samples, scoreboard check.
module running_median_two_heaps_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmth_pkg::*;

  localparam int IN_W = VALUE_WIDTH + 1;
  localparam int OUT_W = VALUE_WIDTH + 11 + 1;
  localparam int STALL_LIMIT = 20000;

  class median_scoreboard;
    int upper_q[$];   // ascending, min at front
    int lower_q[$];   // ascending, max at back
    logic [OUT_W-1:0] pending_q[$];

    function void sorted_add(ref int q[$], input int v);
      int i;
      i = 0;
      while (i < q.size() && q[i] <= v) i++;
      q.insert(i, v);
    endfunction

    function void note_sample(int v, bit clr);
      bit ovf;
      int med;
      int moved;
      ovf = 0;
      med = 0;
      if (clr) begin
        upper_q.delete();
        lower_q.delete();
      end
      if (upper_q.size() == 0 || v >= upper_q[0]) begin
        if (upper_q.size() >= HEAP_DEPTH) begin
          ovf = 1;
        end else begin
          sorted_add(upper_q, v);
          if (upper_q.size() > lower_q.size() + 1) begin
            moved = upper_q.pop_front();
            sorted_add(lower_q, moved);
          end
        end
      end else begin
        if (lower_q.size() >= HEAP_DEPTH) begin
          ovf = 1;
        end else begin
          sorted_add(lower_q, v);
          if (lower_q.size() > upper_q.size() + 1) begin
            moved = lower_q.pop_back();
            sorted_add(upper_q, moved);
          end
        end
      end
      if (upper_q.size() == lower_q.size() + 1) med = upper_q[0];
      else if (lower_q.size() > 0) med = lower_q[$];
      pending_q.push_back({med[31:0], 11'(upper_q.size() + lower_q.size()), ovf});
    endfunction

    function bit check_median(logic [OUT_W-1:0] got, output string why);
      logic [OUT_W-1:0] exp;
      if (pending_q.size() == 0) begin
        why = $sformatf("unexpected result %h", got);
        return 0;
      end
      exp = pending_q.pop_front();
      why = "";
      if (got[43:12] !== exp[43:12])
        why = {why, $sformatf(" median got %0d exp %0d",
                              $signed(got[43:12]), $signed(exp[43:12]))};
      if (got[11:1] !== exp[11:1])
        why = {why, $sformatf(" count got %0d exp %0d", got[11:1], exp[11:1])};
      if (got[0] !== exp[0])
        why = {why, $sformatf(" overflow got %b exp %b", got[0], exp[0])};
      return why == "";
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  rmth_if #(IN_W) in_ch (clk);
  rmth_if #(OUT_W) out_ch (clk);

  running_median_two_heaps_core dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  median_scoreboard sb = new();
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  task automatic report(string why);
    errors++;
    $display("mismatch at %0t:%s", $realtime, why);
  endtask

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    string why;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_sample($signed(in_ch.data[IN_W-1:1]), in_ch.data[0]);
      if (out_ch.valid && out_ch.ready)
        if (!sb.check_median(out_ch.data, why)) report(why);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(int v, bit clr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= {v[31:0], clr};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int pick_value();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(16) - 8;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      3: return $urandom_range(2000) - 1000;
      default: return $urandom_range(1) ? -$urandom_range(100000) : $urandom_range(100000);
    endcase
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_sample(pick_value(), $urandom_range(29) == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty start, extremes, duplicates, clear mid-stream
    send_sample(0, 0);
    send_sample(32'h7fffffff, 0);
    send_sample(32'h80000000, 0);
    send_sample(32'h80000000, 0);
    send_sample(-1, 0);
    send_sample(1, 0);
    send_sample(1, 0);
    send_sample(32'h7fffffff, 0);
    send_sample(32'h55555555, 0);
    send_sample(32'haaaaaaaa, 0);
    send_sample(5, 1);
    send_sample(4, 0);
    send_sample(3, 0);
    send_sample(2, 0);
    send_sample(6, 0);
    send_sample(7, 0);
    send_sample(-7, 1);
    send_sample(-7, 0);
    send_sample(-7, 0);

    send_idle_pct = 7;
    recv_idle_pct = 74;
    random_burst(240);
    send_idle_pct = 74;
    recv_idle_pct = 7;
    random_burst(240);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(220);
    in_ch.valid <= 0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/rmth_pkg.sv
rtl/rmth_if.sv
rtl/rmth_heap.sv
rtl/running_median_two_heaps_core.sv
rtl/rmth_checker.sv
tb/running_median_two_heaps_core_tb.sv
